/* hw/rtl/fasm_pkg.sv */
// Package: shared constants, types and helpers of the substring matcher.
`default_nettype none
package fasm_pkg;

  localparam int PATTERN_MAX = 8;   // longest pattern, in bytes (1..8)
  localparam int INDEX_BITS  = 16;  // width of the text position (8..32)

  localparam int LenW  = $clog2(PATTERN_MAX + 1);
  localparam int IdxW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CfgIdxW = 3;

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_BYTES  = 3'd0,
    CFG_PATTERN_LENGTH = 3'd1,
    CFG_FOLD_CASE      = 3'd2,
    CFG_START_OFFSET   = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic        fold_case;
    logic [15:0] start_offset;
  } cfg_t;

  // Result of one text byte, as computed by the core
  typedef struct packed {
    logic        emit;
    logic        match_found;
    logic [15:0] match_start;
    logic        text_done;
    logic        index_saturated;
  } result_t;

  // ASCII A-Z to a-z when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    fold_byte = (en && b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fasm_if.sv */
// Interfaces: text input, result output and configuration write channels.
`default_nettype none
interface fasm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;
  modport source (output valid, text_byte, text_last, input ready);
  modport sink   (input valid, text_byte, text_last, output ready);
endinterface

interface fasm_result_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [15:0] match_start;
  logic        text_done;
  logic        index_saturated;
  modport source (output valid, match_found, match_start, text_done, index_saturated,
                  input ready);
  modport sink   (input valid, match_found, match_start, text_done, index_saturated,
                  output ready);
endinterface

interface fasm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/find_all_substring_matcher.sv */
// Top level: streaming find-all substring matcher with input and result registers.
//
//  channel  | dir | fields                                            | transfer
//  ---------+-----+---------------------------------------------------+----------------
//  text_i   | in  | text_byte[7:0], text_last                         | valid & ready
//  result_o | out | match_found, match_start[15:0], text_done,        | valid & ready
//           |     | index_saturated                                   |
//  cfg_i    | in  | index[2:0] (0 pattern, 1 length, 2 fold, 3 offset),| valid & ready
//           |     | data[63:0]                                        | (ready always 1)
//
//  One text byte per cycle sustained unless a result stalls; a byte's result is computed
//  from the input register and held in the result register until it transfers. Rate is
//  set by the combinational compare of all pattern slots against the byte history.
//  Reset clears history, position, overflow flag, both pipeline valids and the
//  configuration to its defaults; no clearing pass.
//  A stalled result register holds the input register only when the held byte
//  produces a result; bytes with no result retire regardless.
`default_nettype none
module find_all_substring_matcher
  import fasm_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  fasm_text_if.sink    text_i,
  fasm_result_if.source result_o,
  fasm_cfg_if.sink     cfg_i
);

  cfg_t    cfg;
  result_t res;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Result register
  logic       out_valid_q;
  result_t    out_q;

  logic       out_free;   // result register can take a new result
  logic       step;       // held byte retires this cycle

  fasm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fasm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .step_i (step),
    .res_o  (res)
  );

  assign out_free     = !out_valid_q || result_o.ready;
  assign step         = s1_valid_q && (!res.emit || out_free);
  assign text_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      s1_valid_q <= text_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      s1_byte_q <= text_i.text_byte;
      s1_last_q <= text_i.text_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_q <= res;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.match_found     = out_q.match_found;
  assign result_o.match_start     = out_q.match_start;
  assign result_o.text_done       = out_q.text_done;
  assign result_o.index_saturated = out_q.index_saturated;

  a_result_has_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.match_found |-> out_q.text_done)
    else $error("result without match or end of text");

  a_nomatch_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.match_found |-> out_q.match_start == '0)
    else $error("match_start nonzero without a match");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> out_valid_q && $stable(out_q))
    else $error("pending result lost or overwritten");

endmodule
`default_nettype wire

/* hw/rtl/fasm_cfg_regs.sv */
// Configuration register file of the substring matcher.
`default_nettype none
module fasm_cfg_regs
  import fasm_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  fasm_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes  <= '0;
      cfg_q.pattern_length <= 4'd1;
      cfg_q.fold_case      <= 1'b1;
      cfg_q.start_offset   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= cfg_i.data;
        CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_i.data[3:0];
        CFG_FOLD_CASE:      cfg_q.fold_case      <= cfg_i.data[0];
        CFG_START_OFFSET:   cfg_q.start_offset   <= cfg_i.data[15:0];
        default: ;  // unused index: ignored
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fasm_core.sv */
// Match core: byte history, text position and parallel pattern compare.
`default_nettype none
module fasm_core
  import fasm_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cfg_t       cfg_i,
  input  wire [7:0]  byte_i,
  input  wire        last_i,
  input  wire        step_i,    // the held byte is retired this cycle
  output result_t    res_o
);

  localparam int PosW1 = INDEX_BITS + 1;
  localparam int CmpW  = (INDEX_BITS > 16) ? INDEX_BITS : 16;
  localparam logic [INDEX_BITS-1:0] IndexMax = {INDEX_BITS{1'b1}};
  localparam logic [3:0] PatMax4 = 4'(PATTERN_MAX);

  logic [7:0]            hist_q [PATTERN_MAX];
  logic [7:0]            hist_d [PATTERN_MAX];
  logic [INDEX_BITS-1:0] pos_q;
  logic                  ov_q;

  logic [7:0]            pat    [2**IdxW];
  logic [3:0]            len4;
  logic [LenW-1:0]       len;
  logic [PATTERN_MAX-1:0] hit;
  logic                  eq;
  logic                  reach;
  logic [PosW1-1:0]      pos_inc;
  logic [PosW1-1:0]      start_w;
  logic [INDEX_BITS-1:0] start;
  logic                  start_ok;
  logic                  found;
  logic [IdxW-1:0]       sel [PATTERN_MAX];
  logic [LenW-1:0]       sel_w [PATTERN_MAX];

  // Clamp pattern length to 1..PATTERN_MAX
  always_comb begin
    len4 = cfg_i.pattern_length;
    if (len4 == 4'd0)        len4 = 4'd1;
    else if (len4 > PatMax4) len4 = PatMax4;
    len = LenW'(len4);
  end

  // Folded pattern bytes; entries past PATTERN_MAX never match a live slot
  always_comb begin
    for (int j = 0; j < 2**IdxW; j++) begin
      if (j < PATTERN_MAX) pat[j] = fold_byte(cfg_i.pattern_bytes[8*j +: 8], cfg_i.fold_case);
      else                 pat[j] = '0;
    end
  end

  // History after the shift; slot 0 is the newest byte
  always_comb begin
    hist_d[0] = fold_byte(byte_i, cfg_i.fold_case);
    for (int k = 1; k < PATTERN_MAX; k++) hist_d[k] = hist_q[k-1];
  end

  // Slot k lines up with pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      sel_w[k] = len - LenW'(1) - LenW'(k);
      sel[k]   = sel_w[k][IdxW-1:0];
      hit[k]   = (LenW'(k) >= len) || (pat[sel[k]] == hist_d[k]);
    end
    eq = &hit;
  end

  always_comb begin
    pos_inc  = PosW1'(pos_q) + PosW1'(1);
    reach    = pos_inc >= PosW1'(len);
    start_w  = pos_inc - PosW1'(len);
    start    = start_w[INDEX_BITS-1:0];
    start_ok = CmpW'(start) >= CmpW'(cfg_i.start_offset);
    found    = eq && (ov_q || (reach && start_ok));

    res_o.emit            = found || last_i;
    res_o.match_found     = found;
    res_o.match_start     = found ? 16'(ov_q ? IndexMax : start) : '0;
    res_o.text_done       = last_i;
    res_o.index_saturated = ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PATTERN_MAX; k++) hist_q[k] <= '0;
      pos_q <= '0;
      ov_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        for (int k = 0; k < PATTERN_MAX; k++) hist_q[k] <= '0;
        pos_q <= '0;
        ov_q  <= 1'b0;
      end else begin
        for (int k = 0; k < PATTERN_MAX; k++) hist_q[k] <= hist_d[k];
        if (pos_q == IndexMax) ov_q  <= 1'b1;
        else                   pos_q <= pos_q + INDEX_BITS'(1);
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && !ov_q)
    else $error("text state not cleared after last byte");

  a_ov_pins_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> pos_q == IndexMax)
    else $error("overflow set while position below maximum");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(ov_q))
    else $error("text position moved without a retired byte");

endmodule
`default_nettype wire
